/* rtl/shell_command_tokenizer_top_macros.svh */
// Assertion helpers for the tokenizer top module.
// Each macro expects clk and rst_n in scope; use without a trailing semicolon.
`ifndef SHELL_COMMAND_TOKENIZER_TOP_MACROS_SVH
`define SHELL_COMMAND_TOKENIZER_TOP_MACROS_SVH

// Same-cycle implication.
`define SCL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SCL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/scl_pkg.sv */
package scl_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;

  typedef enum logic [2:0] {
    KIND_WORD    = 3'd0,
    KIND_PIPE    = 3'd1,
    KIND_IN      = 3'd2,
    KIND_OUT     = 3'd3,
    KIND_APPEND  = 3'd4,
    KIND_HEREDOC = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    MODE_GAP    = 4'b0001,
    MODE_PLAIN  = 4'b0010,
    MODE_SQUOTE = 4'b0100,
    MODE_DQUOTE = 4'b1000
  } mode_t;

  typedef enum logic [2:0] {
    PEND_NONE = 3'b001,
    PEND_LT   = 3'b010,
    PEND_GT   = 3'b100
  } pend_t;

  typedef struct packed {
    mode_t mode;
    pend_t pend;
    logic  after_space;
  } lex_state_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       char_valid;
    kind_t      kind;
    logic       first;
    logic       joined;
    logic       line_done;
    logic       last;
  } result_t;

  typedef struct packed {
    result_t    res0;
    result_t    res1;
    logic [1:0] cnt;
    lex_state_t nxt;
  } dec_t;

  localparam lex_state_t STATE_RESET = '{mode: MODE_GAP, pend: PEND_NONE, after_space: 1'b1};

endpackage

/* rtl/shell_command_tokenizer_top.sv */
// Flow: an accepted byte waits in the input stage until the result buffer can take
// it and its results are offered from there. Throughput: one byte per cycle while
// out_ready is high; a byte with two results (held < or > flushed, or a doubled
// << / >>) holds the result buffer, and so the input, until both are taken.
// Reset (rst_n low, synchronous): input and result stages empty, lexer back to line
// start (between segments, nothing held, next segment starts a new word).
module shell_command_tokenizer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_char_valid,
  output logic [2:0] out_token_kind,
  output logic       out_token_first,
  output logic       out_joined,
  output logic       out_line_done,
  output logic       out_last
);

  `include "shell_command_tokenizer_top_macros.svh"

  // Input stage: one byte waiting for decode.
  logic [7:0]          char_r, char_nxt;
  logic                in_v_r, in_v_nxt;
  // Lexer state, advanced when a byte moves into the result buffer.
  scl_pkg::lex_state_t st_r, st_nxt;

  scl_pkg::dec_t    dec;
  scl_pkg::result_t out_res;
  logic             can_load;
  logic             load;

  scl_decode u_decode (
    .in_char (char_r),
    .st      (st_r),
    .dec     (dec)
  );

  // Move the held byte into the result buffer whenever the buffer drains.
  assign load     = in_v_r && can_load;
  // Take a new byte while the input stage is empty or is emptying now.
  assign in_ready = !in_v_r || load;

  scl_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .res0      (dec.res0),
    .res1      (dec.res1),
    .cnt       (dec.cnt),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_char        = out_res.ch;
  assign out_char_valid  = out_res.char_valid;
  assign out_token_kind  = out_res.kind;
  assign out_token_first = out_res.first;
  assign out_joined      = out_res.joined;
  assign out_line_done   = out_res.line_done;
  assign out_last        = out_res.last;

  always_comb begin
    char_nxt = char_r;
    in_v_nxt = in_v_r;
    st_nxt   = st_r;
    if (load) begin
      st_nxt   = dec.nxt;
      in_v_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      char_nxt = in_char;
      in_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    if (!rst_n) begin
      in_v_r <= 1'b0;
      st_r   <= scl_pkg::STATE_RESET;
    end else begin
      in_v_r <= in_v_nxt;
      st_r   <= st_nxt;
    end
  end

  // A held operator only exists in the gap after it, with a new word to follow.
  `SCL_ASSERT_IMP(a_pend_in_gap, st_r.pend != scl_pkg::PEND_NONE,
    st_r.mode == scl_pkg::MODE_GAP && st_r.after_space, "held operator outside gap")
  `SCL_ASSERT_IMP(a_eol_last, out_valid && out_line_done,
    out_last && !out_char_valid, "end marker not last or carries a byte")
  `SCL_ASSERT_IMP(a_join_first, out_valid && out_joined,
    out_token_first && out_token_kind == scl_pkg::KIND_WORD, "joined off a word start")
  `SCL_ASSERT_NXT(a_load_shows, load && dec.cnt != 2'd0, out_valid,
    "loaded results not offered")

endmodule

/* rtl/scl_decode.sv */
module scl_decode (
  input  logic [7:0]          in_char,
  input  scl_pkg::lex_state_t st,
  output scl_pkg::dec_t       dec
);

  logic              held_v;
  logic [7:0]        held_c;
  scl_pkg::result_t  held_res;
  scl_pkg::result_t  main_res;
  logic              main_v;

  always_comb begin
    held_v   = (st.pend == scl_pkg::PEND_LT) || (st.pend == scl_pkg::PEND_GT);
    held_c   = (st.pend == scl_pkg::PEND_LT) ? scl_pkg::CH_LT : scl_pkg::CH_GT;
    held_res = '{ch: held_c, char_valid: 1'b1,
                 kind: (st.pend == scl_pkg::PEND_LT) ? scl_pkg::KIND_IN : scl_pkg::KIND_OUT,
                 first: 1'b1, joined: 1'b0, line_done: 1'b0, last: 1'b0};
    main_res = '{ch: in_char, char_valid: 1'b1, kind: scl_pkg::KIND_WORD,
                 first: 1'b0, joined: 1'b0, line_done: 1'b0, last: 1'b0};
    main_v   = 1'b0;
    dec      = '0;
    dec.nxt  = st;
    dec.nxt.pend = scl_pkg::PEND_NONE;

    // Classify the byte as it would be without a held operator.
    if (in_char == scl_pkg::CH_NUL) begin
      main_v             = 1'b1;
      main_res.ch        = scl_pkg::CH_NUL;
      main_res.char_valid = 1'b0;
      main_res.line_done = 1'b1;
      dec.nxt            = scl_pkg::STATE_RESET;
    end else if (st.mode == scl_pkg::MODE_SQUOTE || st.mode == scl_pkg::MODE_DQUOTE) begin
      main_v = 1'b1;
      if ((st.mode == scl_pkg::MODE_SQUOTE && in_char == scl_pkg::CH_SQ) ||
          (st.mode == scl_pkg::MODE_DQUOTE && in_char == scl_pkg::CH_DQ)) begin
        dec.nxt.mode        = scl_pkg::MODE_GAP;
        dec.nxt.after_space = 1'b0;
      end
    end else if (in_char == scl_pkg::CH_SPACE) begin
      dec.nxt.mode        = scl_pkg::MODE_GAP;
      dec.nxt.after_space = 1'b1;
    end else if (in_char == scl_pkg::CH_PIPE) begin
      main_v              = 1'b1;
      main_res.kind       = scl_pkg::KIND_PIPE;
      main_res.first      = 1'b1;
      dec.nxt.mode        = scl_pkg::MODE_GAP;
      dec.nxt.after_space = 1'b1;
    end else if (in_char == scl_pkg::CH_LT || in_char == scl_pkg::CH_GT) begin
      dec.nxt.pend = (in_char == scl_pkg::CH_LT) ? scl_pkg::PEND_LT : scl_pkg::PEND_GT;
      dec.nxt.mode        = scl_pkg::MODE_GAP;
      dec.nxt.after_space = 1'b1;
    end else if (in_char == scl_pkg::CH_SQ || in_char == scl_pkg::CH_DQ) begin
      main_v              = 1'b1;
      main_res.first      = 1'b1;
      main_res.joined     = ~st.after_space;
      dec.nxt.mode = (in_char == scl_pkg::CH_SQ) ? scl_pkg::MODE_SQUOTE
                                                 : scl_pkg::MODE_DQUOTE;
      dec.nxt.after_space = 1'b0;
    end else if (st.mode == scl_pkg::MODE_PLAIN) begin
      main_v = 1'b1;
    end else begin
      main_v              = 1'b1;
      main_res.first      = 1'b1;
      main_res.joined     = ~st.after_space;
      dec.nxt.mode        = scl_pkg::MODE_PLAIN;
      dec.nxt.after_space = 1'b0;
    end

    // Merge the held operator in front of the byte's own result.
    if (held_v && in_char == held_c) begin
      dec.res0      = held_res;
      dec.res0.kind = (st.pend == scl_pkg::PEND_LT) ? scl_pkg::KIND_HEREDOC
                                                    : scl_pkg::KIND_APPEND;
      dec.res1       = dec.res0;
      dec.res1.first = 1'b0;
      dec.res1.last  = 1'b1;
      dec.cnt        = 2'd2;
      dec.nxt        = st;
      dec.nxt.pend   = scl_pkg::PEND_NONE;
    end else if (held_v && main_v) begin
      dec.res0      = held_res;
      dec.res1      = main_res;
      dec.res1.last = 1'b1;
      dec.cnt       = 2'd2;
    end else if (held_v) begin
      dec.res0      = held_res;
      dec.res0.last = 1'b1;
      dec.cnt       = 2'd1;
    end else if (main_v) begin
      dec.res0      = main_res;
      dec.res0.last = 1'b1;
      dec.cnt       = 2'd1;
    end
  end

endmodule

/* rtl/scl_outbuf.sv */
module scl_outbuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  scl_pkg::result_t  res0,
  input  scl_pkg::result_t  res1,
  input  logic [1:0]        cnt,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output scl_pkg::result_t  out_res
);

  scl_pkg::result_t slot0_r, slot0_nxt;
  scl_pkg::result_t slot1_r, slot1_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_res   = slot0_r;
  assign pop       = out_valid && out_ready;
  // Refill only once the buffer drains this cycle.
  assign can_load  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && pop);

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_r;
    if (load) begin
      slot0_nxt = res0;
      slot1_nxt = res1;
      cnt_nxt   = cnt;
    end else if (pop) begin
      slot0_nxt = slot1_r;
      cnt_nxt   = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

  // Watchdog: worst case is about 500 bytes, each with an input gap and two results
  // that each sit out an output stall; this limit leaves a wide margin over that.
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char;
  logic       out_char_valid;
  logic [2:0] out_token_kind;
  logic       out_token_first;
  logic       out_joined;
  logic       out_line_done;
  logic       out_last;

  // Lexer state as seen by the predictor.
  scl_pkg::mode_t lex_mode = scl_pkg::MODE_GAP;
  scl_pkg::pend_t held_op = scl_pkg::PEND_NONE;
  logic           new_word = 1'b1;

  // Token bytes still owed by the block, oldest first.
  scl_pkg::result_t expected_tokens[$];
  scl_pkg::result_t want;

  // Idle controls and bookkeeping.
  logic sender_idle = 1'b0;
  logic sink_stall = 1'b0;
  int   stall_left = 0;
  int   cycles = 0;
  int   mismatches = 0;
  int   items_sent = 0;
  int   lines_sent = 0;
  int   results_seen = 0;

  shell_command_tokenizer_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char         (in_char),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char        (out_char),
    .out_char_valid  (out_char_valid),
    .out_token_kind  (out_token_kind),
    .out_token_first (out_token_first),
    .out_joined      (out_joined),
    .out_line_done   (out_line_done),
    .out_last        (out_last)
  );

  always #5 clk = ~clk;

  // Give up on a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Queue one expected token byte; the last flag is set once the byte is done.
  function automatic void push_token(logic [7:0] ch, logic valid, scl_pkg::kind_t kind,
                                     logic first, logic join_prev, logic done);
    scl_pkg::result_t r;
    r.ch = ch;
    r.char_valid = valid;
    r.kind = kind;
    r.first = first;
    r.joined = join_prev;
    r.line_done = done;
    r.last = 1'b0;
    expected_tokens.push_back(r);
  endfunction

  // Advance the lexer by one accepted byte and queue the token bytes it causes.
  function automatic void predict_tokens(logic [7:0] c);
    logic [7:0]     held;
    scl_pkg::kind_t dbl_kind;
    int             base;
    base = expected_tokens.size();
    // Resolve a held < or >: a matching byte doubles it, anything else flushes it.
    if (held_op == scl_pkg::PEND_LT || held_op == scl_pkg::PEND_GT) begin
      held = (held_op == scl_pkg::PEND_LT) ? scl_pkg::CH_LT : scl_pkg::CH_GT;
      held_op = scl_pkg::PEND_NONE;
      if (c == held) begin
        dbl_kind = (held == scl_pkg::CH_LT) ? scl_pkg::KIND_HEREDOC : scl_pkg::KIND_APPEND;
        push_token(held, 1'b1, dbl_kind, 1'b1, 1'b0, 1'b0);
        push_token(held, 1'b1, dbl_kind, 1'b0, 1'b0, 1'b0);
        expected_tokens[expected_tokens.size() - 1].last = 1'b1;
        return;
      end
      push_token(held, 1'b1, (held == scl_pkg::CH_LT) ? scl_pkg::KIND_IN : scl_pkg::KIND_OUT,
                 1'b1, 1'b0, 1'b0);
    end
    held_op = scl_pkg::PEND_NONE;

    if (c == scl_pkg::CH_NUL) begin
      // End of line: emit the marker and return to line start.
      push_token(scl_pkg::CH_NUL, 1'b0, scl_pkg::KIND_WORD, 1'b0, 1'b0, 1'b1);
      lex_mode = scl_pkg::MODE_GAP;
      new_word = 1'b1;
    end else if (lex_mode == scl_pkg::MODE_SQUOTE || lex_mode == scl_pkg::MODE_DQUOTE) begin
      // Inside quotes every nonzero byte is literal; only the matching quote closes.
      push_token(c, 1'b1, scl_pkg::KIND_WORD, 1'b0, 1'b0, 1'b0);
      if (c == ((lex_mode == scl_pkg::MODE_SQUOTE) ? scl_pkg::CH_SQ : scl_pkg::CH_DQ)) begin
        lex_mode = scl_pkg::MODE_GAP;
        new_word = 1'b0;
      end
    end else if (c == scl_pkg::CH_SPACE) begin
      lex_mode = scl_pkg::MODE_GAP;
      new_word = 1'b1;
    end else if (c == scl_pkg::CH_PIPE) begin
      push_token(c, 1'b1, scl_pkg::KIND_PIPE, 1'b1, 1'b0, 1'b0);
      lex_mode = scl_pkg::MODE_GAP;
      new_word = 1'b1;
    end else if (c == scl_pkg::CH_LT || c == scl_pkg::CH_GT) begin
      held_op = (c == scl_pkg::CH_LT) ? scl_pkg::PEND_LT : scl_pkg::PEND_GT;
      lex_mode = scl_pkg::MODE_GAP;
      new_word = 1'b1;
    end else if (c == scl_pkg::CH_SQ || c == scl_pkg::CH_DQ) begin
      push_token(c, 1'b1, scl_pkg::KIND_WORD, 1'b1, ~new_word, 1'b0);
      lex_mode = (c == scl_pkg::CH_SQ) ? scl_pkg::MODE_SQUOTE : scl_pkg::MODE_DQUOTE;
      new_word = 1'b0;
    end else if (lex_mode == scl_pkg::MODE_PLAIN) begin
      push_token(c, 1'b1, scl_pkg::KIND_WORD, 1'b0, 1'b0, 1'b0);
    end else begin
      push_token(c, 1'b1, scl_pkg::KIND_WORD, 1'b1, ~new_word, 1'b0);
      lex_mode = scl_pkg::MODE_PLAIN;
      new_word = 1'b0;
    end

    if (expected_tokens.size() > base)
      expected_tokens[expected_tokens.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(string name, logic [7:0] exp_val, logic [7:0] got);
    if (exp_val !== got) begin
      $error("%s: expected %0h, got %0h", name, exp_val, got);
      mismatches++;
    end
  endfunction

  // Check each accepted result against the oldest expectation, then pick the
  // next out_ready value: random stall bursts while enabled.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_tokens.size() == 0) begin
        $error("unexpected result: out_char %0h, line_done %0b", out_char, out_line_done);
        mismatches++;
      end else begin
        want = expected_tokens.pop_front();
        check_field("out_char", want.ch, out_char);
        check_field("char_valid", 8'(want.char_valid), 8'(out_char_valid));
        check_field("token_kind", 8'(want.kind), 8'(out_token_kind));
        check_field("token_first", 8'(want.first), 8'(out_token_first));
        check_field("joined", 8'(want.joined), 8'(out_joined));
        check_field("line_done", 8'(want.line_done), 8'(out_line_done));
        check_field("last", 8'(want.last), 8'(out_last));
      end
    end
    if (sink_stall && stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (sink_stall && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 11);
      out_ready <= 1'b0;
    end else begin
      stall_left = 0;
      out_ready <= 1'b1;
    end
  end

  // Offer one byte, optionally after an idle burst, and hold it until accepted.
  task automatic send_byte(input logic [7:0] c);
    int gap;
    if (sender_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_tokens(c);
    items_sent++;
    if (c == scl_pkg::CH_NUL)
      lines_sent++;
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i]);
  endtask

  // Any nonzero byte that does not split or quote, biased toward lowercase letters.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do begin
      if ($urandom_range(0, 3) == 0)
        b = 8'($urandom_range(1, 255));
      else
        b = 8'($urandom_range(97, 122));
    end while (b == scl_pkg::CH_SPACE || b == scl_pkg::CH_PIPE || b == scl_pkg::CH_LT ||
               b == scl_pkg::CH_GT || b == scl_pkg::CH_SQ || b == scl_pkg::CH_DQ);
    return b;
  endfunction

  // Any nonzero byte except the quote that would close the run.
  function automatic logic [7:0] quoted_byte(logic [7:0] q);
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == q);
    return b;
  endfunction

  // Build a well-formed line from random pieces; some quotes are left open.
  task automatic send_random_line();
    int pieces;
    int n;
    int pick;
    logic [7:0] q;
    pieces = $urandom_range(1, 6);
    repeat (pieces) begin
      pick = $urandom_range(0, 9);
      case (pick) inside
        [0:3]: begin
          n = $urandom_range(1, 4);
          repeat (n) send_byte(plain_byte());
        end
        [4:5]: begin
          q = (pick == 4) ? scl_pkg::CH_SQ : scl_pkg::CH_DQ;
          send_byte(q);
          n = $urandom_range(0, 3);
          repeat (n) send_byte(quoted_byte(q));
          if ($urandom_range(0, 7) != 0)
            send_byte(q);
        end
        6: begin
          n = $urandom_range(1, 2);
          repeat (n) send_byte(scl_pkg::CH_SPACE);
        end
        7: begin
          // Runs of 1 to 3 operator bytes: singles, doubles and a double plus one.
          if ($urandom_range(0, 2) == 0)
            q = scl_pkg::CH_PIPE;
          else
            q = $urandom_range(0, 1) ? scl_pkg::CH_LT : scl_pkg::CH_GT;
          n = $urandom_range(1, 3);
          repeat (n) send_byte(q);
        end
        8: send_byte(8'($urandom_range(1, 255)));
        default: ;
      endcase
    end
    send_byte(scl_pkg::CH_NUL);
  endtask

  // Hold until every expected result has come, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // An empty line straight after reset: only the end marker.
  task automatic test_empty_line();
    send_byte(scl_pkg::CH_NUL);
  endtask

  // Top byte value, a double-quoted run holding a space, a control byte joined
  // to it, a single-quoted segment joined to that word, then end of line.
  task automatic test_quotes_and_joins();
    send_byte(8'hFF);
    send_string("\" \"");
    send_byte(8'h01);
    send_string("'q'");
    send_byte(scl_pkg::CH_NUL);
  endtask

  // Append, heredoc, doubled pipe, a held < flushed by a plain byte, and a
  // held > flushed by the end of line.
  task automatic test_operators();
    send_string(">><<||<");
    send_byte(8'h7F);
    send_byte(scl_pkg::CH_GT);
    send_byte(scl_pkg::CH_NUL);
  endtask

  // A quote left open runs to the end of line.
  task automatic test_open_quote();
    send_byte(scl_pkg::CH_DQ);
    send_byte(8'h80);
    send_byte(scl_pkg::CH_NUL);
  endtask

  // Bulk of the run: random well-formed lines; toggle idling per line so that
  // some stretches run with no gaps at all.
  task automatic test_random_lines();
    while (items_sent < 400) begin
      sender_idle = ($urandom_range(0, 3) != 0);
      sink_stall = ($urandom_range(0, 3) != 0);
      send_random_line();
    end
  endtask

  // Raw bytes of any value, zeros included, then close the line.
  task automatic test_random_noise();
    sender_idle = 1'b1;
    sink_stall = 1'b1;
    repeat (60) begin
      if ($urandom_range(0, 15) == 0)
        send_byte(scl_pkg::CH_NUL);
      else
        send_byte(8'($urandom_range(0, 255)));
    end
    send_byte(scl_pkg::CH_NUL);
  endtask

  // Finish at full rate on both sides.
  task automatic test_steady_stream();
    int start;
    sender_idle = 1'b0;
    sink_stall = 1'b0;
    start = items_sent;
    while (items_sent - start < 40)
      send_random_line();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idle = 1'b1;
    sink_stall = 1'b1;
    test_empty_line();
    test_quotes_and_joins();
    test_operators();
    test_open_quote();
    test_random_lines();
    test_random_noise();
    test_steady_stream();
    drain();

    $display("Tokenized %0d bytes over %0d lines; %0d results checked.",
             items_sent, lines_sent, results_seen);
    $display("Covered operators, quoting, joins, byte extremes and random stalls.");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
